// ===== src/greedy_delta_r_matcher_top_defines.svh =====
// assertion helpers for the matcher
`ifndef GREEDY_DELTA_R_MATCHER_TOP_DEFINES_SVH
`define GREEDY_DELTA_R_MATCHER_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define GDR_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("violated: label");

// antecedent implies consequent in the next cycle
`define GDR_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("violated: label");

`endif

// ===== src/gdrm_pkg.sv =====
package gdrm_pkg;

  localparam int unsigned OP_W = 2;
  localparam logic [OP_W-1:0] OP_LOAD_RECO  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_TRUTH = 2'd1;
  localparam logic [OP_W-1:0] OP_RUN        = 2'd2;
  localparam logic [OP_W-1:0] OP_IGNORE     = 2'd3;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RECO_PT_MIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRUTH_PT_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ETA_MAX      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DR_MAX_SQ    = 2'd3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned PT_W  = 16;
  localparam int unsigned ETA_W = 16;
  localparam int unsigned PHI_W = 15;
  localparam int unsigned OBJ_W = PT_W + ETA_W + PHI_W;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned IDX_OUT_W = 4;

  localparam logic signed [16:0] PHI_PI     = 17'sd12868;
  localparam logic signed [16:0] PHI_TWO_PI = 17'sd25736;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [PT_W-1:0]         pt;
    logic signed [ETA_W-1:0] eta;
    logic signed [PHI_W-1:0] phi;
  } cmd_t;

  typedef struct packed {
    logic                 match_valid;
    logic [IDX_OUT_W-1:0] reco_index;
    logic [IDX_OUT_W-1:0] truth_index;
    logic [31:0]          dist_sq;
    logic                 overflow;
    logic                 last;
  } res_t;

endpackage

// ===== src/greedy_delta_r_matcher_top.sv =====
// channel  | direction | handshake    | payload
// input    | in        | push / full  | op, obj_pt, obj_eta, obj_phi
// result   | out       | empty / pop  | match_valid .. last
// config   | in        | cfg_we       | cfg_index, cfg_data
// loads are taken one per cycle into a 4-entry command queue while it is not
// full, then written to the tables one per cycle while idle. a run steps each
// slot pair through the pair pipeline in each search pass (one pass per match
// plus a final pass). a match is held back until the next pass shows whether it
// is the last one. rst is synchronous and clears all control state; tables need
// no clearing. either side may stall freely: results wait while the queue fills.
module greedy_delta_r_matcher_top import gdrm_pkg::*; #(
  parameter int unsigned RECO_SLOTS  = 16,
  parameter int unsigned TRUTH_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        op,
  input  logic [15:0]       obj_pt,
  input  logic signed [15:0] obj_eta,
  input  logic signed [14:0] obj_phi,
  output logic              empty,
  input  logic              pop,
  output logic              match_valid,
  output logic [3:0]        reco_index,
  output logic [3:0]        truth_index,
  output logic [31:0]       dist_sq,
  output logic              overflow,
  output logic              last,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  logic [15:0] reco_pt_min, truth_pt_min;
  logic [14:0] eta_max;
  logic [31:0] dr_max_sq;
  cmd_t in_cmd, q_cmd;
  res_t res;
  logic q_valid, q_take, res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      reco_pt_min <= 16'd80;
      truth_pt_min <= 16'd80;
      eta_max <= 15'd4506;
      dr_max_sq <= 32'd2684354;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RECO_PT_MIN:  reco_pt_min <= cfg_data[15:0];
        REG_TRUTH_PT_MIN: truth_pt_min <= cfg_data[15:0];
        REG_ETA_MAX:      eta_max <= cfg_data[14:0];
        REG_DR_MAX_SQ:    dr_max_sq <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_cmd = '{op: op, pt: obj_pt, eta: obj_eta, phi: obj_phi};

  gdrm_front #(.DEPTH(4)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_cmd(in_cmd),
    .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd)
  );

  gdrm_back #(.RECO_SLOTS(RECO_SLOTS), .TRUTH_SLOTS(TRUTH_SLOTS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd),
    .reco_pt_min(reco_pt_min), .truth_pt_min(truth_pt_min), .eta_max(eta_max),
    .dr_max_sq(dr_max_sq), .res_valid(res_valid), .res(res), .res_take(pop)
  );

  assign empty = !res_valid;
  assign match_valid = res.match_valid;
  assign reco_index = res.reco_index;
  assign truth_index = res.truth_index;
  assign dist_sq = res.dist_sq;
  assign overflow = res.overflow;
  assign last = res.last;

endmodule

// ===== src/gdrm_ram.sv =====
module gdrm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== src/gdrm_front.sv =====
module gdrm_front import gdrm_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  cmd_t in_cmd,
  output logic q_valid,
  input  logic q_take,
  output cmd_t q_cmd
);

  localparam int unsigned AW = $clog2(DEPTH);

  cmd_t           buf_q [DEPTH];
  logic [AW-1:0]  wptr, rptr;
  logic [AW:0]    count;
  logic           wr, rd;

  // op 3 carries no work and is dropped here
  assign wr = push && !full && (in_cmd.op != OP_IGNORE);
  assign rd = q_valid && q_take;
  assign full = (count == (AW+1)'(DEPTH));
  assign q_valid = (count != '0);
  assign q_cmd = buf_q[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= (wptr == AW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      if (rd) rptr <= (rptr == AW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      count <= count + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) buf_q[wptr] <= in_cmd;
  end

endmodule

// ===== src/gdrm_back.sv =====
`include "greedy_delta_r_matcher_top_defines.svh"
module gdrm_back import gdrm_pkg::*; #(
  parameter int unsigned RECO_SLOTS  = 16,
  parameter int unsigned TRUTH_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_take,
  input  cmd_t        q_cmd,
  input  logic [15:0] reco_pt_min,
  input  logic [15:0] truth_pt_min,
  input  logic [14:0] eta_max,
  input  logic [31:0] dr_max_sq,
  output logic        res_valid,
  output res_t        res,
  input  logic        res_take
);

  localparam int unsigned RW = (RECO_SLOTS > 1) ? $clog2(RECO_SLOTS) : 1;
  localparam int unsigned TW = (TRUTH_SLOTS > 1) ? $clog2(TRUTH_SLOTS) : 1;
  localparam int unsigned NW = $clog2(MAX_RESULTS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_CALC  = 3'd2;
  localparam logic [2:0] S_SQ    = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state, state_next;

  logic [RW:0] reco_fill;
  logic [TW:0] truth_fill;
  logic [RECO_SLOTS-1:0]  reco_taken;
  logic [TRUTH_SLOTS-1:0] truth_taken;
  logic dropped_flag;
  logic [NW-1:0] n_res;

  logic [RW-1:0] r_i;
  logic [TW-1:0] t_i;
  logic [OBJ_W-1:0] reco_rd, truth_rd;
  logic [RW-1:0] reco_ra;
  logic [TW-1:0] truth_ra;
  logic reco_we, truth_we;

  // pair pipeline registers
  logic [RW-1:0] p_r;
  logic [TW-1:0] p_t;
  logic          p_ok;
  logic signed [16:0] de;
  logic signed [16:0] dp;
  logic [33:0]   d_sum;

  logic          found;
  logic [RW-1:0] br;
  logic [TW-1:0] bt;
  logic [33:0]   bd;
  logic          last_pair;

  // match waiting until the next pass tells whether it is the last
  logic          pend_v;
  logic [RW-1:0] pend_r;
  logic [TW-1:0] pend_t;
  logic [33:0]   pend_d;
  logic          fin;

  logic          win, fb_found;
  logic [RW-1:0] fb_r;
  logic [TW-1:0] fb_t;
  logic [33:0]   fb_d;

  logic [PT_W-1:0]         r_pt, t_pt;
  logic signed [ETA_W-1:0] r_eta, t_eta;
  logic signed [PHI_W-1:0] r_phi, t_phi;
  logic [ETA_W-1:0] r_aeta, t_aeta;
  logic r_elig, t_elig;
  logic signed [16:0] dp_raw, dp_wr;
  logic [33:0] sq_e, sq_p;
  logic [31:0] sat;

  assign {r_pt, r_eta, r_phi} = reco_rd;
  assign {t_pt, t_eta, t_phi} = truth_rd;
  assign r_aeta = r_eta[ETA_W-1] ? ETA_W'(-r_eta) : r_eta;
  assign t_aeta = t_eta[ETA_W-1] ? ETA_W'(-t_eta) : t_eta;
  assign r_elig = (r_pt >= reco_pt_min) && ({1'b0, r_aeta} <= {2'b0, eta_max});
  assign t_elig = (t_pt >= truth_pt_min) && ({1'b0, t_aeta} <= {2'b0, eta_max});
  // phi inputs lie within one wrap of the range
  assign dp_raw = 17'(r_phi) - 17'(t_phi);
  assign dp_wr = (dp_raw > PHI_PI) ? dp_raw - PHI_TWO_PI :
                 (dp_raw < -PHI_PI) ? dp_raw + PHI_TWO_PI : dp_raw;
  assign sq_e = 34'(de) * 34'(de);
  assign sq_p = 34'(dp) * 34'(dp);
  assign sat = (pend_d[33:32] != 2'b0) ? 32'hFFFF_FFFF : pend_d[31:0];

  // strict less keeps the earliest pair on ties
  assign win = p_ok && (d_sum < {2'b0, dr_max_sq}) && (!found || d_sum < bd);
  assign fb_found = found || win;
  assign fb_r = win ? p_r : br;
  assign fb_t = win ? p_t : bt;
  assign fb_d = win ? d_sum : bd;

  assign reco_we  = q_valid && state == S_IDLE && q_cmd.op == OP_LOAD_RECO
                    && reco_fill < (RW+1)'(RECO_SLOTS);
  assign truth_we = q_valid && state == S_IDLE && q_cmd.op == OP_LOAD_TRUTH
                    && truth_fill < (TW+1)'(TRUTH_SLOTS);
  assign reco_ra  = r_i;
  assign truth_ra = t_i;

  gdrm_ram #(.WIDTH(OBJ_W), .DEPTH(RECO_SLOTS)) u_reco (
    .clk(clk), .we(reco_we), .waddr(reco_fill[RW-1:0]),
    .wdata({q_cmd.pt, q_cmd.eta, q_cmd.phi}), .raddr(reco_ra), .rdata(reco_rd)
  );
  gdrm_ram #(.WIDTH(OBJ_W), .DEPTH(TRUTH_SLOTS)) u_truth (
    .clk(clk), .we(truth_we), .waddr(truth_fill[TW-1:0]),
    .wdata({q_cmd.pt, q_cmd.eta, q_cmd.phi}), .raddr(truth_ra), .rdata(truth_rd)
  );

  // the run item leaves the queue as its search starts
  assign q_take = q_valid && state == S_IDLE;
  assign res_valid = (state == S_EMIT) || (state == S_DONE);

  always_comb begin
    res.match_valid = (state == S_EMIT);
    res.reco_index  = (state == S_EMIT) ? IDX_OUT_W'(pend_r) : '0;
    res.truth_index = (state == S_EMIT) ? IDX_OUT_W'(pend_t) : '0;
    res.dist_sq     = (state == S_EMIT) ? sat : '0;
    res.overflow    = dropped_flag;
    res.last        = (state == S_DONE) || (state == S_EMIT && fin);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (q_valid && q_cmd.op == OP_RUN) state_next = S_SCAN;
      // read pair (r_i, t_i); data arrives next cycle
      S_SCAN: state_next = S_CALC;
      S_CALC: state_next = S_SQ;
      S_SQ:   state_next = S_CMP;
      S_CMP: begin
        if (!last_pair) state_next = S_SCAN;
        else if (pend_v) state_next = S_EMIT;
        else state_next = fb_found ? S_SCAN : S_DONE;
      end
      S_EMIT: if (res_take) begin
        if (fin) state_next = S_IDLE;
        else state_next = (n_res == NW'(MAX_RESULTS - 2)) ? S_EMIT : S_SCAN;
      end
      S_DONE: if (res_take) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      reco_fill <= '0;
      truth_fill <= '0;
      reco_taken <= '0;
      truth_taken <= '0;
      dropped_flag <= 1'b0;
      n_res <= '0;
      found <= 1'b0;
      r_i <= '0;
      t_i <= '0;
      last_pair <= 1'b0;
      pend_v <= 1'b0;
      fin <= 1'b0;
    end else begin
      state <= state_next;
      if (reco_we) reco_fill <= reco_fill + 1'b1;
      if (truth_we) truth_fill <= truth_fill + 1'b1;
      if (q_take && q_cmd.op != OP_RUN && !reco_we && !truth_we) dropped_flag <= 1'b1;
      unique case (state)
        S_IDLE: begin
          r_i <= '0;
          t_i <= '0;
          found <= 1'b0;
        end
        S_SCAN: begin
          p_r <= r_i;
          p_t <= t_i;
          last_pair <= ((RW+1)'(r_i) + 1'b1 >= reco_fill) &&
                       ((TW+1)'(t_i) + 1'b1 >= truth_fill);
          if ((TW+1)'(t_i) + 1'b1 >= truth_fill) begin
            t_i <= '0;
            r_i <= r_i + 1'b1;
          end else begin
            t_i <= t_i + 1'b1;
          end
        end
        S_CALC: begin
          p_ok <= ((RW+1)'(p_r) < reco_fill) && ((TW+1)'(p_t) < truth_fill) &&
                  !reco_taken[p_r] && !truth_taken[p_t] && r_elig && t_elig;
          de <= 17'(r_eta) - 17'(t_eta);
          dp <= dp_wr;
        end
        S_SQ: d_sum <= sq_e + sq_p;
        S_CMP: begin
          if (last_pair) begin
            r_i <= '0;
            t_i <= '0;
          end
          if (last_pair && fb_found && !pend_v) begin
            // first match of the run waits while the next pass runs
            pend_v <= 1'b1;
            pend_r <= fb_r;
            pend_t <= fb_t;
            pend_d <= fb_d;
            reco_taken[fb_r] <= 1'b1;
            truth_taken[fb_t] <= 1'b1;
            found <= 1'b0;
          end else if (win) begin
            found <= 1'b1;
            bd <= d_sum;
            br <= p_r;
            bt <= p_t;
          end
          if (last_pair && !fb_found && pend_v) fin <= 1'b1;
        end
        S_EMIT: if (res_take) begin
          if (fin) begin
            reco_fill <= '0;
            truth_fill <= '0;
            reco_taken <= '0;
            truth_taken <= '0;
            dropped_flag <= 1'b0;
            n_res <= '0;
            pend_v <= 1'b0;
            fin <= 1'b0;
            found <= 1'b0;
          end else begin
            pend_r <= br;
            pend_t <= bt;
            pend_d <= bd;
            reco_taken[br] <= 1'b1;
            truth_taken[bt] <= 1'b1;
            found <= 1'b0;
            r_i <= '0;
            t_i <= '0;
            n_res <= n_res + 1'b1;
            if (n_res == NW'(MAX_RESULTS - 2)) fin <= 1'b1;
          end
        end
        S_DONE: if (res_take) begin
          reco_fill <= '0;
          truth_fill <= '0;
          reco_taken <= '0;
          truth_taken <= '0;
          dropped_flag <= 1'b0;
          n_res <= '0;
          pend_v <= 1'b0;
          fin <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  `GDR_ASSERT_IMP(a_fill_bound, clk, rst, 1'b1, reco_fill <= (RW+1)'(RECO_SLOTS))
  `GDR_ASSERT_IMP(a_emit_pend, clk, rst, state == S_EMIT, pend_v)
  `GDR_ASSERT_NEXT(a_done_clears, clk, rst, state == S_DONE && res_take, reco_fill == '0 && !dropped_flag)

endmodule
